// ===== rtl/mfv_pkg.sv =====
`timescale 1ns / 1ps

package mfv_pkg;

  // Number of list elements kept in the element store.
  localparam int DEPTH = 64;

  // Store address width and element counter width (the counter also holds DEPTH itself).
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Field widths.
  localparam int VAL_W  = 32;
  localparam int FREQ_W = 7;

endpackage

// ===== rtl/most_frequent_value.sv =====
`timescale 1ns / 1ps

// The result becomes valid once the closing word is accepted and the pairwise search ends,
// and is held back while an earlier result is still stalled at the output.
// The single read port of the element store sets the search length: every later element is read
// once for each earlier element.
// Throughput: one input word per cycle in S_LOAD; input is stalled in every other state.
// Reset (rst_n low, synchronous) empties the list, clears the overflow flag and drops any result.
module most_frequent_value (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [mfv_pkg::VAL_W-1:0] in_value,
  input  logic                             in_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [mfv_pkg::VAL_W-1:0] out_mode_value,
  output logic [mfv_pkg::FREQ_W-1:0]       out_frequency,
  output logic                             out_overflow
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_PIVOT,
    S_PWAIT,
    S_SCAN,
    S_EVAL,
    S_FINISH
  } state_t;

  // Element store: one write port for loading, one registered read port for the search.
  logic [mfv_pkg::VAL_W-1:0]  mem [mfv_pkg::DEPTH];
  logic [mfv_pkg::VAL_W-1:0]  rd_data_r;
  logic [mfv_pkg::ADDR_W-1:0] rd_addr;
  logic                       wr_en;

  state_t                     state_r, state_nxt;
  logic [mfv_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [mfv_pkg::ADDR_W-1:0] i_r, i_nxt;
  logic [mfv_pkg::CNT_W-1:0]  j_r, j_nxt;
  logic                       rd_pend_r, rd_pend_nxt;
  logic [mfv_pkg::VAL_W-1:0]  pivot_r, pivot_nxt;
  logic [mfv_pkg::CNT_W-1:0]  c_r, c_nxt;
  logic [mfv_pkg::VAL_W-1:0]  top_val_r, top_val_nxt;
  logic [mfv_pkg::CNT_W-1:0]  top_cnt_r, top_cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [mfv_pkg::VAL_W-1:0]  out_val_r, out_val_nxt;
  logic [mfv_pkg::FREQ_W-1:0] out_freq_r, out_freq_nxt;
  logic                       out_ovf_r, out_ovf_nxt;

  logic                       in_acc;
  logic                       store_room;
  logic [mfv_pkg::CNT_W-1:0]  i_next_cnt;

  assign in_stall   = (state_r != S_LOAD);
  assign in_acc     = in_valid && !in_stall;
  assign store_room = (cnt_r < mfv_pkg::CNT_W'(mfv_pkg::DEPTH));
  assign wr_en      = in_acc && store_room;
  assign i_next_cnt = mfv_pkg::CNT_W'(i_r) + mfv_pkg::CNT_W'(1);

  assign out_valid      = out_valid_r;
  assign out_mode_value = out_val_r;
  assign out_frequency  = out_freq_r;
  assign out_overflow   = out_ovf_r;

  // Element store write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[mfv_pkg::ADDR_W-1:0]] <= in_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Next-state logic for loading, the pairwise search and the result register.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rd_pend_nxt   = rd_pend_r;
    pivot_nxt     = pivot_r;
    c_nxt         = c_r;
    top_val_nxt   = top_val_r;
    top_cnt_nxt   = top_cnt_r;
    out_val_nxt   = out_val_r;
    out_freq_nxt  = out_freq_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_addr       = i_r;

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (store_room) begin
            cnt_nxt = cnt_r + mfv_pkg::CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            i_nxt       = '0;
            top_val_nxt = '0;
            top_cnt_nxt = '0;
            state_nxt   = S_PIVOT;
          end
        end
      end

      // Read the pivot element.
      S_PIVOT: begin
        rd_addr   = i_r;
        state_nxt = S_PWAIT;
      end

      // Capture the pivot and start the scan over later elements.
      S_PWAIT: begin
        pivot_nxt   = rd_data_r;
        c_nxt       = mfv_pkg::CNT_W'(1);
        j_nxt       = i_next_cnt;
        rd_pend_nxt = 1'b0;
        state_nxt   = S_SCAN;
      end

      // One read issued and one compare done per cycle.
      S_SCAN: begin
        rd_addr = j_r[mfv_pkg::ADDR_W-1:0];
        if (rd_pend_r && (rd_data_r == pivot_r)) begin
          c_nxt = c_r + mfv_pkg::CNT_W'(1);
        end
        if (j_r < cnt_r) begin
          j_nxt       = j_r + mfv_pkg::CNT_W'(1);
          rd_pend_nxt = 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
          state_nxt   = S_EVAL;
        end
      end

      // Keep the pivot only on a strictly larger count, so the earliest wins ties.
      S_EVAL: begin
        if (c_r > top_cnt_r) begin
          top_cnt_nxt = c_r;
          top_val_nxt = pivot_r;
        end
        if (i_next_cnt < cnt_r) begin
          i_nxt     = i_r + mfv_pkg::ADDR_W'(1);
          state_nxt = S_PIVOT;
        end else begin
          state_nxt = S_FINISH;
        end
      end

      // Hand the result over once the output register is free.
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = top_val_r;
          out_freq_nxt  = mfv_pkg::FREQ_W'(top_cnt_r);
          out_ovf_nxt   = ovf_r;
          cnt_nxt       = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_LOAD;
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      top_val_r   <= '0;
      top_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      top_val_r   <= top_val_nxt;
      top_cnt_r   <= top_cnt_nxt;
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    pivot_r    <= pivot_nxt;
    c_r        <= c_nxt;
    out_val_r  <= out_val_nxt;
    out_freq_r <= out_freq_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

endmodule
